### design/frt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_pkg: shared constants and types
// Sizes, the controller state type and the command bundle of the replacement
// tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int DEPTH    = 16;
	localparam int ID_WIDTH = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam int PTID_W = 16;
	localparam int EVID_W = 16;
	localparam int OCC_W  = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load_id;
		logic lookup;
		logic update;
	} cmd_t;

endpackage

### design/frt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_if: channel interfaces
// Valid/ready channels for the identifier input and the result output.
// ----------------------------------------------------------------------------
interface frt_in_if;
	logic                      valid;
	logic                      ready;
	logic [frt_pkg::PTID_W-1:0] page_table_id;

	modport source (output valid, output page_table_id, input ready);
	modport sink   (input valid, input page_table_id, output ready);
endinterface

interface frt_out_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic                       evicted_valid;
	logic [frt_pkg::EVID_W-1:0] evicted_id;
	logic [frt_pkg::OCC_W-1:0]  occupancy;

	modport source (output valid, output hit, output evicted_valid, output evicted_id,
		output occupancy, input ready);
	modport sink   (input valid, input hit, input evicted_valid, input evicted_id,
		input occupancy, output ready);
endinterface

### design/frt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_ctrl: sequencing controller
// Steps each identifier through lookup and list update, and owns the
// result register's valid flag.
// ----------------------------------------------------------------------------
module frt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output frt_pkg::cmd_t cmd
);
	import frt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_id = 1'b1;
					state_d     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					cmd.update = 1'b1;
					in_ready   = 1'b1;
					if (in_valid) begin
						cmd.load_id = 1'b1;
						state_d     = ST_LOOK;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/frt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_dp: resident list datapath
// Holds the ordered list, count and mode; parallel compare, then shift and
// append with the result register.
// ----------------------------------------------------------------------------
module frt_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frt_pkg::cmd_t              cmd,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_wr_data,
	input  logic [frt_pkg::PTID_W-1:0] page_table_id,
	output logic                       hit,
	output logic                       evicted_valid,
	output logic [frt_pkg::EVID_W-1:0] evicted_id,
	output logic [frt_pkg::OCC_W-1:0]  occupancy
);
	import frt_pkg::*;

	logic [ID_WIDTH-1:0] list_q [DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic                mode_q;
	logic [ID_WIDTH-1:0] id_q;
	logic                hit_q;
	logic [IDX_W-1:0]    pos_q;

	logic [DEPTH-1:0]    match;
	logic                any_match;
	logic [IDX_W-1:0]    first_pos;

	logic                full;
	logic                shift_en;
	logic                wr_en;
	logic [IDX_W-1:0]    rp;
	logic [IDX_W-1:0]    last;
	logic [IDX_W-1:0]    widx;
	logic [CNT_W-1:0]    cnt_next;
	logic                evict;

	always_comb begin
		first_pos = '0;
		for (int i = 0; i < DEPTH; i++)
			match[i] = (CNT_W'(i) < count_q) && (list_q[i] == id_q);
		for (int i = DEPTH - 1; i >= 0; i--)
			if (match[i])
				first_pos = IDX_W'(i);
		any_match = |match;
	end

	assign full = (count_q == CNT_W'(DEPTH));

	always_comb begin
		shift_en = 1'b0;
		wr_en    = 1'b0;
		rp       = '0;
		last     = '0;
		widx     = '0;
		evict    = 1'b0;
		cnt_next = count_q;
		if (hit_q) begin
			if (mode_q) begin
				shift_en = 1'b1;
				wr_en    = 1'b1;
				rp       = pos_q;
				last     = IDX_W'(count_q - 1'b1);
				widx     = IDX_W'(count_q - 1'b1);
			end
		end else if (!full) begin
			wr_en    = 1'b1;
			widx     = IDX_W'(count_q);
			cnt_next = count_q + 1'b1;
		end else begin
			shift_en = 1'b1;
			wr_en    = 1'b1;
			evict    = 1'b1;
			rp       = '0;
			last     = IDX_W'(DEPTH - 1);
			widx     = IDX_W'(DEPTH - 1);
		end
	end

	// shift range ends below widx, so each entry takes at most one write
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int i = 0; i < DEPTH - 1; i++)
				if (shift_en && IDX_W'(i) >= rp && IDX_W'(i) < last)
					list_q[i] <= list_q[i+1];
			for (int i = 0; i < DEPTH; i++)
				if (wr_en && IDX_W'(i) == widx)
					list_q[i] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				mode_q <= cfg_wr_data;
			if (cmd.update)
				count_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_id)
			id_q <= ID_WIDTH'(page_table_id);
		if (cmd.lookup) begin
			hit_q <= any_match;
			pos_q <= first_pos;
		end
		if (cmd.update) begin
			hit           <= hit_q;
			evicted_valid <= evict;
			evicted_id    <= evict ? EVID_W'(list_q[0]) : '0;
			occupancy     <= OCC_W'(cnt_next);
		end
	end

endmodule

### design/fifo_lru_replacement_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_lru_replacement_tracker_core: FIFO/LRU replacement tracker
// Sequence: the input transfer loads the id register, lookup registers hit and
// position, update writes the list and result; a new identifier is taken only
// in idle or update, and a stalled result register holds off update.
// Reset: count, mode and handshake state clear asynchronously; list contents
// are not cleared and only entries below the count are ever read.
// ----------------------------------------------------------------------------
module fifo_lru_replacement_tracker_core (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	frt_in_if.sink    in_ch,
	frt_out_if.source out_ch
);
	import frt_pkg::*;

	cmd_t cmd;

	frt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	frt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.page_table_id (in_ch.page_table_id),
		.hit           (out_ch.hit),
		.evicted_valid (out_ch.evicted_valid),
		.evicted_id    (out_ch.evicted_id),
		.occupancy     (out_ch.occupancy)
	);

endmodule

### design/frt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frt_checker: port-level checks
// Result consistency and output stall behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module frt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       hit,
	input logic                       evicted_valid,
	input logic [frt_pkg::EVID_W-1:0] evicted_id,
	input logic [frt_pkg::OCC_W-1:0]  occupancy
);
	import frt_pkg::*;

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_valid |-> !hit)
		else $error("eviction reported on a hit");

	a_evict_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_id == '0)
		else $error("evicted_id nonzero without eviction");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_valid |-> occupancy == OCC_W'(DEPTH))
		else $error("eviction while list not full");

	a_occ_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy != '0 || DEPTH % (1 << OCC_W) == 0)
		else $error("empty list after an access");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(occupancy) && $stable(evicted_id))
		else $error("stalled result changed");

endmodule

bind fifo_lru_replacement_tracker_core frt_checker u_frt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.hit           (out_ch.hit),
	.evicted_valid (out_ch.evicted_valid),
	.evicted_id    (out_ch.evicted_id),
	.occupancy     (out_ch.occupancy)
);
